// ===== hdl/sine_cosine_quarter_table_unit_defines.svh =====
// Assertion macros for the sine/cosine quarter table unit.
// Included by the top level; depends on nothing else.
`ifndef SINE_COSINE_QUARTER_TABLE_UNIT_DEFINES_SVH
`define SINE_COSINE_QUARTER_TABLE_UNIT_DEFINES_SVH

// The condition must hold whenever the trigger holds, outside reset.
`define SCTQ_ASSERT_IMPLIES(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("sctq: implication check failed");

// The condition must hold a fixed number of cycles after the trigger.
`define SCTQ_ASSERT_DELAY(label, clk, rst_n, trig, dly, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> ##dly (cond)) \
        else $error("sctq: delayed check failed");

`endif

// ===== hdl/sctq_pkg.sv =====
// Constants, types and the quarter-wave sine table for the sine/cosine unit.
// Standalone package; used by sine_cosine_quarter_table_unit.
package sctq_pkg;

    typedef logic [1:0] sctq_quad_t;

    localparam int unsigned TWO_PI_Q16  = 411775;
    localparam int unsigned HALF_PI_Q16 = 102944;
    localparam int unsigned ROM_DEPTH   = 256;

    // A multiple of 2*pi that makes every possible angle sum non-negative.
    localparam logic [32:0] MOD_OFFSET = 33'(64'd411775 * 64'd5216);

    // floor(2^33 / 2*pi): the quotient estimate is low by at most one.
    localparam logic [14:0] MOD_RECIP = 15'((64'd1 << 33) / 64'(TWO_PI_Q16));

    // ceil(2^46 / (pi/2)): exact floor division for products below 2^29.
    localparam logic [29:0] IDX_RECIP =
        30'(((64'd1 << 46) + 64'(HALF_PI_Q16) - 64'd1) / 64'(HALF_PI_Q16));

    localparam int unsigned PIPE_DEPTH = 9;

    localparam logic [15:0] QUARTER_ROM [0:255] = '{
        16'd0, 16'd402, 16'd804, 16'd1206, 16'd1608, 16'd2010, 16'd2412, 16'd2814,
        16'd3216, 16'd3617, 16'd4019, 16'd4420, 16'd4821, 16'd5222, 16'd5623, 16'd6023,
        16'd6424, 16'd6824, 16'd7224, 16'd7623, 16'd8022, 16'd8421, 16'd8820, 16'd9218,
        16'd9616, 16'd10014, 16'd10411, 16'd10808, 16'd11204, 16'd11600, 16'd11996,
        16'd12391,
        16'd12785, 16'd13180, 16'd13573, 16'd13966, 16'd14359, 16'd14751, 16'd15143,
        16'd15534,
        16'd15924, 16'd16314, 16'd16703, 16'd17091, 16'd17479, 16'd17867, 16'd18253,
        16'd18639,
        16'd19024, 16'd19409, 16'd19792, 16'd20175, 16'd20557, 16'd20939, 16'd21320,
        16'd21699,
        16'd22078, 16'd22457, 16'd22834, 16'd23210, 16'd23586, 16'd23961, 16'd24335,
        16'd24708,
        16'd25080, 16'd25451, 16'd25821, 16'd26190, 16'd26558, 16'd26925, 16'd27291,
        16'd27656,
        16'd28020, 16'd28383, 16'd28745, 16'd29106, 16'd29466, 16'd29824, 16'd30182,
        16'd30538,
        16'd30893, 16'd31248, 16'd31600, 16'd31952, 16'd32303, 16'd32652, 16'd33000,
        16'd33347,
        16'd33692, 16'd34037, 16'd34380, 16'd34721, 16'd35062, 16'd35401, 16'd35738,
        16'd36075,
        16'd36410, 16'd36744, 16'd37076, 16'd37407, 16'd37736, 16'd38064, 16'd38391,
        16'd38716,
        16'd39040, 16'd39362, 16'd39683, 16'd40002, 16'd40320, 16'd40636, 16'd40951,
        16'd41264,
        16'd41576, 16'd41886, 16'd42194, 16'd42501, 16'd42806, 16'd43110, 16'd43412,
        16'd43713,
        16'd44011, 16'd44308, 16'd44604, 16'd44898, 16'd45190, 16'd45480, 16'd45769,
        16'd46056,
        16'd46341, 16'd46624, 16'd46906, 16'd47186, 16'd47464, 16'd47741, 16'd48015,
        16'd48288,
        16'd48559, 16'd48828, 16'd49095, 16'd49361, 16'd49624, 16'd49886, 16'd50146,
        16'd50404,
        16'd50660, 16'd50914, 16'd51166, 16'd51417, 16'd51665, 16'd51911, 16'd52156,
        16'd52398,
        16'd52639, 16'd52878, 16'd53114, 16'd53349, 16'd53581, 16'd53812, 16'd54040,
        16'd54267,
        16'd54491, 16'd54714, 16'd54934, 16'd55152, 16'd55368, 16'd55582, 16'd55794,
        16'd56004,
        16'd56212, 16'd56418, 16'd56621, 16'd56823, 16'd57022, 16'd57219, 16'd57414,
        16'd57607,
        16'd57798, 16'd57986, 16'd58172, 16'd58356, 16'd58538, 16'd58718, 16'd58896,
        16'd59071,
        16'd59244, 16'd59415, 16'd59583, 16'd59750, 16'd59914, 16'd60075, 16'd60235,
        16'd60392,
        16'd60547, 16'd60700, 16'd60851, 16'd60999, 16'd61145, 16'd61288, 16'd61429,
        16'd61568,
        16'd61705, 16'd61839, 16'd61971, 16'd62101, 16'd62228, 16'd62353, 16'd62476,
        16'd62596,
        16'd62714, 16'd62830, 16'd62943, 16'd63054, 16'd63162, 16'd63268, 16'd63372,
        16'd63473,
        16'd63572, 16'd63668, 16'd63763, 16'd63854, 16'd63944, 16'd64031, 16'd64115,
        16'd64197,
        16'd64277, 16'd64354, 16'd64429, 16'd64501, 16'd64571, 16'd64639, 16'd64704,
        16'd64766,
        16'd64827, 16'd64884, 16'd64940, 16'd64993, 16'd65043, 16'd65091, 16'd65137,
        16'd65180,
        16'd65220, 16'd65259, 16'd65294, 16'd65328, 16'd65358, 16'd65387, 16'd65413,
        16'd65436,
        16'd65457, 16'd65476, 16'd65492, 16'd65505, 16'd65516, 16'd65525, 16'd65531,
        16'd65535
    };

endpackage

// ===== hdl/sine_cosine_quarter_table_unit.sv =====
// Sine/cosine of a Q16.16 angle from a quarter-wave table, fully pipelined.
// Depends on sctq_pkg and sine_cosine_quarter_table_unit_defines.svh.
`include "sine_cosine_quarter_table_unit_defines.svh"

// The unit accepts one request on every clock cycle (busy is always low) and
// returns each result after it has passed through every stage, in request order,
// as a one-cycle pulse on done with the value alongside. The receiver cannot
// stall, so it must take the result in that cycle. The nine stages are the
// input register, the modulo-2*pi reduction (estimate multiply, back-multiply,
// correction with the quadrant split), the two index-scaling multiplies, the
// rescale onto the stored entries, the registered quarter-wave table read and
// the output negation.
module sine_cosine_quarter_table_unit #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [16:0] value
);
    import sctq_pkg::*;

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam int PNW  = 17 + IDXW;
    localparam int IPW  = PNW + 30;
    localparam int PPW  = IDXW + 29;
    localparam logic [IDXW-1:0] TOP   = IDXW'(TABLE_ENTRIES - 1);
    localparam logic [IDXW:0]   TOP_X = (IDXW + 1)'(TABLE_ENTRIES - 1);
    // ceil(255 * 2^24 / (entries - 1)): exact rescale onto the 256 stored entries.
    localparam logic [28:0] POS_RECIP =
        29'(((64'd255 << 24) + 64'(TABLE_ENTRIES - 1) - 64'd1) / 64'(TABLE_ENTRIES - 1));

    logic [PIPE_DEPTH-1:0] vld_reg, vld_next;

    logic [32:0]     u_reg, u_next;
    logic [32:0]     u1_reg;
    logic [14:0]     q_reg, q_next;
    logic [19:0]     r0_reg, r0_next;
    logic [16:0]     phase_reg, phase_next;
    sctq_quad_t      quad_reg, quad_next;
    logic [PNW-1:0]  pn_reg, pn_next;
    sctq_quad_t      quad4_reg;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic            neg5_reg, neg6_reg, neg7_reg;
    logic [7:0]      pos_reg, pos_next;
    logic [15:0]     rom_reg;
    logic signed [16:0] value_reg, value_next;

    logic [47:0]     qprod;
    logic [33:0]     qd;
    logic [33:0]     rdiff;
    logic [19:0]     rsub;
    logic [18:0]     rmod;
    logic [IPW-1:0]  iprod;
    logic [IDXW:0]   idx_raw;
    logic [IDXW-1:0] idx_cl;
    logic [PPW-1:0]  pprod;
    logic [IDXW+4:0] pos_raw;

    always_comb
    begin
        vld_next = {vld_reg[PIPE_DEPTH-2:0], start};

        // Stage 0: optional quarter-turn shift, then offset to a non-negative sum.
        u_next = {angle[31], angle} + (mode ? 33'(HALF_PI_Q16) : 33'd0) + MOD_OFFSET;

        // Stage 1: quotient estimate by reciprocal multiplication.
        qprod  = 48'(u_reg) * 48'(MOD_RECIP);
        q_next = qprod[47:33];

        // Stage 2: remainder, at most one modulus too large.
        qd      = 34'(q_reg) * 34'(TWO_PI_Q16);
        rdiff   = {1'b0, u1_reg} - qd;
        r0_next = rdiff[19:0];

        // Stage 3: final correction, then quadrant and phase by threshold compare.
        rsub = r0_reg - 20'(TWO_PI_Q16);
        rmod = (r0_reg >= 20'(TWO_PI_Q16)) ? rsub[18:0] : r0_reg[18:0];
        if (rmod >= 19'(3 * HALF_PI_Q16))
        begin
            quad_next  = 2'd3;
            phase_next = 17'(rmod - 19'(3 * HALF_PI_Q16));
        end
        else if (rmod >= 19'(2 * HALF_PI_Q16))
        begin
            quad_next  = 2'd2;
            phase_next = 17'(rmod - 19'(2 * HALF_PI_Q16));
        end
        else if (rmod >= 19'(HALF_PI_Q16))
        begin
            quad_next  = 2'd1;
            phase_next = 17'(rmod - 19'(HALF_PI_Q16));
        end
        else
        begin
            quad_next  = 2'd0;
            phase_next = rmod[16:0];
        end

        // Stage 4: phase times the last table index.
        pn_next = PNW'(phase_reg) * PNW'(TOP);

        // Stage 5: divide by pi/2, clamp, and mirror in odd quadrants.
        iprod   = IPW'(pn_reg) * IPW'(IDX_RECIP);
        idx_raw = iprod[IPW-1:46];
        idx_cl  = (idx_raw > TOP_X) ? TOP : idx_raw[IDXW-1:0];
        idx_next = quad4_reg[0] ? (TOP - idx_cl) : idx_cl;

        // Stage 6: rescale the index onto the stored entries.
        pprod    = PPW'(idx_reg) * PPW'(POS_RECIP);
        pos_raw  = pprod[PPW-1:24];
        pos_next = (pos_raw > (IDXW + 5)'(ROM_DEPTH - 1)) ? 8'hff : pos_raw[7:0];

        // Stage 8: negate in the lower half turn.
        value_next = neg7_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        u1_reg    <= u_reg;
        q_reg     <= q_next;
        r0_reg    <= r0_next;
        phase_reg <= phase_next;
        quad_reg  <= quad_next;
        pn_reg    <= pn_next;
        quad4_reg <= quad_reg;
        idx_reg   <= idx_next;
        neg5_reg  <= quad4_reg[1];
        pos_reg   <= pos_next;
        neg6_reg  <= neg5_reg;
        rom_reg   <= QUARTER_ROM[pos_reg];
        neg7_reg  <= neg6_reg;
        value_reg <= value_next;
    end

    assign busy  = 1'b0;
    assign done  = vld_reg[PIPE_DEPTH-1];
    assign value = value_reg;

    `SCTQ_ASSERT_DELAY(a_latency, clk, rst_n, start, 9, done)
    `SCTQ_ASSERT_IMPLIES(a_no_orphan, clk, rst_n, done, $past(start, 9))
    `SCTQ_ASSERT_IMPLIES(a_phase_range, clk, rst_n, vld_reg[3], phase_reg < 17'(HALF_PI_Q16))
    `SCTQ_ASSERT_IMPLIES(a_value_range, clk, rst_n, done, value != -17'sd65536)

endmodule
